### src/wlps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wang-Landau Potts step package
// Shared widths, register indexes and defaults for the Wang-Landau sampler.
// ----------------------------------------------------------------------------
package wlps_pkg;

	// Default sizing of the lattice, spin alphabet and energy histogram.
	localparam int DEF_MAX_SIDE    = 16;
	localparam int DEF_MAX_LEVELS  = 8;
	localparam int DEF_ENERGY_BINS = 513;

	// Fixed field widths of the item and configuration ports.
	localparam int SPIN_W   = 4;
	localparam int UNI_W    = 16;
	localparam int STAGE_W  = 5;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 16;
	localparam int CHK_W    = 16;
	localparam int MC_W     = 16;

	// Log density is unsigned Q24.24; visit counts saturate at 32 bits.
	localparam int LOGD_W    = 48;
	localparam int FRAC_W    = 24;
	localparam int CNT_W     = 32;
	localparam int STAGE_MAX = 24;

	// Exponential series: Q32 values need 33 bits, twelve terms.
	localparam int EXP_W     = 33;
	localparam int EXP_TERMS = 12;
	localparam int DIV_VW    = 16;

	// Register reset values.
	localparam int SIDE_DEF   = 15;
	localparam int LEVELS_DEF = 2;
	localparam int CHECK_DEF  = 100;
	localparam int FINAL_DEF  = 14;

	// Configuration register indexes.
	typedef enum logic [CFG_IW-1:0] {
		REG_SIDE   = 2'd0,
		REG_LEVELS = 2'd1,
		REG_CHECK  = 2'd2,
		REG_FINAL  = 2'd3
	} cfg_reg_t;

endpackage

### src/wang_landau_potts_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wang-Landau Potts step
// Wang-Landau sampler for a periodic 2D q-state Potts lattice with a shared
// multiplier, a shared bit-serial divider and a small sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. One result follows
// on the result ports for a single cycle, marked by done. The receiver cannot
// stall, so the result must be taken in that cycle. Done rises in the same
// cycle that busy falls. A load holds busy through the spin reads (the center
// and four neighbors through one registered port), an energy update and the
// result state. A move without a series evaluation adds two density reads,
// the gate and the visit. A move whose density rise lies between 0 and 16.0
// also evaluates a twelve-term exponential series. Each term takes one
// multiply and a bit-serial divide, and one more multiply by exp(-1) follows
// per whole unit of the rise. Every check_interval moves, a flatness pass
// walks all ENERGY_BINS bins, one a cycle. A flat histogram then adds a
// clearing sweep of all ENERGY_BINS bins. After reset, the block clears the
// density and histogram memories one bin a cycle and then evaluates exp(-1)
// once. Busy stays high during this time, but configuration writes are
// taken. Writing check_interval while idle starts a residue recompute that
// holds busy.
module wang_landau_potts_step #(
	parameter int MAX_SIDE    = wlps_pkg::DEF_MAX_SIDE,
	parameter int MAX_LEVELS  = wlps_pkg::DEF_MAX_LEVELS,
	parameter int ENERGY_BINS = wlps_pkg::DEF_ENERGY_BINS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// Request channel
	input  logic                                       start,
	output logic                                       busy,
	input  logic                                       action,
	input  logic [$clog2(MAX_SIDE)-1:0]                row,
	input  logic [$clog2(MAX_SIDE)-1:0]                col,
	input  logic [wlps_pkg::SPIN_W-1:0]                spin,
	input  logic [wlps_pkg::UNI_W-1:0]                 uniform,
	// Result channel
	output logic                                       done,
	output logic                                       accepted,
	output logic signed [$clog2(2*MAX_SIDE*MAX_SIDE):0] energy,
	output logic [wlps_pkg::STAGE_W-1:0]               stage,
	output logic                                       flat_now,
	output logic                                       finished,
	output logic                                       status,
	// Configuration channel
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [wlps_pkg::CFG_IW-1:0]                cfg_index,
	input  logic [wlps_pkg::CFG_DW-1:0]                cfg_data
);
	import wlps_pkg::*;

	localparam int RCW      = $clog2(MAX_SIDE);
	localparam int SW       = $clog2(MAX_SIDE + 1);
	localparam int LW       = $clog2(MAX_LEVELS + 1);
	localparam int NSITE    = MAX_SIDE * MAX_SIDE;
	localparam int AW       = $clog2(NSITE);
	localparam int EW       = $clog2(2 * NSITE) + 1;
	localparam int BW       = $clog2(ENERGY_BINS);
	localparam int CW       = $clog2(ENERGY_BINS + 1);
	localparam int SUMW     = CNT_W + CW;
	localparam int SIDE_RST = (SIDE_DEF > MAX_SIDE) ? MAX_SIDE : SIDE_DEF;
	localparam int E_RST    = -2 * SIDE_RST * SIDE_RST;
	localparam int PW       = 2 * EXP_W;

	localparam logic [EXP_W-1:0]  ONE_Q32  = EXP_W'(1) << 32;
	localparam logic [EXP_W-1:0]  ONE_Q24X = EXP_W'(1) << FRAC_W;
	localparam logic [LOGD_W-1:0] LOGD_MAX = '1;
	localparam logic [LOGD_W-1:0] D_LIMIT  = LOGD_W'(16) << FRAC_W;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD, S_EVAL, S_LD_N, S_LD_O, S_CMP, S_GATE,
		S_EX_MUL, S_EX_DIV0, S_DIV, S_EX_ACC, S_EX_END, S_PW_MUL, S_PW_SH,
		S_DECIDE, S_VISIT, S_FL_RD, S_FL_MUL, S_FL_CMP, S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SW-1:0]      side_q;
	logic [LW-1:0]      levels_q;
	logic [CHK_W-1:0]   ci_q;
	logic [STAGE_W-1:0] final_q;

	// Sampler state.
	logic signed [EW-1:0] energy_q;
	logic [STAGE_W-1:0]   halving_q;
	logic [MC_W-1:0]      mc_q;
	logic [CHK_W-1:0]     res_q;
	logic                 init_q;
	logic                 clr_all_q;

	// Latched request.
	logic              act_q;
	logic [RCW-1:0]    row_q;
	logic [RCW-1:0]    col_q;
	logic [LW-1:0]     sp_q;
	logic [UNI_W-1:0]  u_q;

	// Per-item working registers.
	logic [2:0]            rd_cnt_q;
	logic [LW-1:0]         old_q;
	logic [2:0]            eqn_q;
	logic [2:0]            eqo_q;
	logic signed [EW-1:0]  enew_q;
	logic [BW-1:0]         bn_q;
	logic [BW-1:0]         bo_q;
	logic [LOGD_W-1:0]     ln_n_q;
	logic [LOGD_W-1:0]     ln_o_q;
	logic [CNT_W-1:0]      cn_n_q;
	logic [CNT_W-1:0]      cn_o_q;
	logic                  take_q;
	logic                  acc_q;
	logic                  flat_q;
	logic                  stat_q;

	// Exponential series and power loop.
	logic [EXP_W-1:0]        x_q;
	logic [EXP_W-1:0]        term_q;
	logic signed [EXP_W+1:0] sum_q;
	logic [3:0]              k_q;
	logic [3:0]              n_q;
	logic [EXP_W-1:0]        r_q;
	logic [EXP_W-1:0]        e1_q;
	logic                    exp_e1_q;

	// Shared divider.
	logic [EXP_W-1:0]  div_num_q;
	logic [DIV_VW-1:0] div_den_q;
	logic [DIV_VW-1:0] div_rem_q;
	logic [5:0]        div_cnt_q;
	logic              div_res_q;

	// Sweep and flatness accumulation.
	logic [CW-1:0]   swp_q;
	logic [SUMW-1:0] fsum_q;
	logic [CW-1:0]   fcnt_q;
	logic [CNT_W-1:0] fmn_q;

	// Shared multiplier.
	logic [EXP_W-1:0] mul_a;
	logic [EXP_W-1:0] mul_b;
	logic [PW-1:0]    prod_q;

	// Result registers.
	logic                 done_q;
	logic                 out_acc_q;
	logic signed [EW-1:0] out_energy_q;
	logic [STAGE_W-1:0]   out_stage_q;
	logic                 out_flat_q;
	logic                 out_fin_q;
	logic                 out_stat_q;

	// Memories and their ports.
	logic [LW-1:0]     sp_mem [NSITE];
	logic              sp_vld_q [NSITE];
	logic [LW-1:0]     sp_rd_q;
	logic              sp_vrd_q;
	logic [AW-1:0]     sp_raddr;
	logic              sp_we;
	logic [AW-1:0]     site;
	logic [LW-1:0]     spv;

	logic [LOGD_W-1:0] ld_mem [ENERGY_BINS];
	logic [CNT_W-1:0]  cn_mem [ENERGY_BINS];
	logic [LOGD_W-1:0] ld_rd_q;
	logic [CNT_W-1:0]  cn_rd_q;
	logic [BW-1:0]     lm_raddr;
	logic [BW-1:0]     lm_waddr;
	logic              ld_we;
	logic              cn_we;
	logic [LOGD_W-1:0] ld_wd;
	logic [CNT_W-1:0]  cn_wd;

	// Visit datapath.
	logic [BW-1:0]     bv;
	logic [LOGD_W-1:0] ln_b;
	logic [CNT_W-1:0]  cn_b;
	logic [LOGD_W-1:0] inc;

	// Divider step.
	logic [DIV_VW:0]   div_sh;
	logic              div_ge;
	logic [DIV_VW-1:0] div_rem_nx;

	// Combinational helpers.
	logic              cfg_take;
	logic [SW-1:0]     side_nx;
	logic [2*SW:0]     sq2;
	logic [LW-1:0]     sp_in;
	logic              oor;
	logic              fin_now;
	logic [RCW-1:0]    up_r;
	logic [RCW-1:0]    dn_r;
	logic [RCW-1:0]    lf_c;
	logic [RCW-1:0]    rt_c;
	logic signed [EW-1:0] enew_c;
	logic [LOGD_W-1:0] dlog;
	logic [EXP_W-1:0]  sum_clip;
	logic [CHK_W-1:0]  ci_eff;
	logic [SUMW+2:0]   flat_lhs;
	logic [SUMW+2:0]   flat_rhs;
	logic              flat_ok;

	// Energy to histogram bin: the magnitude of a negative energy, saturated.
	function automatic logic [BW-1:0] bin_of(input logic signed [EW-1:0] e);
		logic [EW:0] mag;
		begin
			mag = e[EW-1] ? ((EW+1)'(0) - {e[EW-1], e}) : '0;
			if (32'(mag) > 32'(ENERGY_BINS - 1)) begin
				bin_of = BW'(ENERGY_BINS - 1);
			end else begin
				bin_of = BW'(mag);
			end
		end
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [RCW-1:0] r,
			input logic [RCW-1:0] c);
		addr_of = AW'(int'(r) * MAX_SIDE + int'(c));
	endfunction

	// Configuration values, clamped into their legal ranges.
	assign cfg_ready = ((state_q == S_IDLE) && !start) || init_q;
	assign cfg_take  = cfg_valid && cfg_ready;
	always_comb begin
		if (cfg_data[4:0] < 5'd2) begin
			side_nx = SW'(2);
		end else if (32'(cfg_data[4:0]) > 32'(MAX_SIDE)) begin
			side_nx = SW'(MAX_SIDE);
		end else begin
			side_nx = SW'(cfg_data[4:0]);
		end
		sq2 = ((2*SW+1)'(side_nx) * (2*SW+1)'(side_nx)) << 1;
	end

	// Requested spin: zero acts as one, above q acts as q.
	always_comb begin
		if (spin == '0) begin
			sp_in = LW'(1);
		end else if (32'(spin) > 32'(levels_q)) begin
			sp_in = levels_q;
		end else begin
			sp_in = LW'(spin);
		end
	end

	assign oor     = (SW'(row) >= side_q) || (SW'(col) >= side_q);
	assign fin_now = halving_q >= final_q;
	assign ci_eff  = (ci_q == '0) ? CHK_W'(1) : ci_q;

	// Periodic neighbors of the latched site.
	assign up_r = (row_q == '0) ? RCW'(side_q - SW'(1)) : row_q - RCW'(1);
	assign dn_r = ((SW'(row_q) + SW'(1)) == side_q) ? '0 : row_q + RCW'(1);
	assign lf_c = (col_q == '0) ? RCW'(side_q - SW'(1)) : col_q - RCW'(1);
	assign rt_c = ((SW'(col_q) + SW'(1)) == side_q) ? '0 : col_q + RCW'(1);
	assign site = addr_of(row_q, col_q);

	// Spin read address: center first, then the four neighbors.
	always_comb begin
		unique case (rd_cnt_q)
			3'd1:    sp_raddr = addr_of(up_r, col_q);
			3'd2:    sp_raddr = addr_of(dn_r, col_q);
			3'd3:    sp_raddr = addr_of(row_q, lf_c);
			3'd4:    sp_raddr = addr_of(row_q, rt_c);
			default: sp_raddr = site;
		endcase
	end

	assign spv    = sp_vrd_q ? sp_rd_q : LW'(1);
	assign sp_we  = ((state_q == S_EVAL) && !act_q) || ((state_q == S_VISIT) && take_q);
	assign enew_c = energy_q - $signed(EW'(eqn_q)) + $signed(EW'(eqo_q));

	// Spin memory; never-written or cleared sites read as one through sp_vld_q.
	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[site] <= sp_q;
		end
		sp_rd_q  <= sp_mem[sp_raddr];
		sp_vrd_q <= sp_vld_q[sp_raddr];
	end

	// Visit operands follow the acceptance decision.
	assign bv   = take_q ? bn_q : bo_q;
	assign ln_b = take_q ? ln_n_q : ln_o_q;
	assign cn_b = take_q ? cn_n_q : cn_o_q;
	assign inc  = LOGD_W'(1) << (STAGE_W'(STAGE_MAX) - halving_q);
	assign dlog = ln_n_q - ln_o_q;

	// Density and histogram memory ports.
	always_comb begin
		lm_raddr = '0;
		lm_waddr = '0;
		ld_we    = 1'b0;
		cn_we    = 1'b0;
		ld_wd    = '0;
		cn_wd    = '0;
		unique case (state_q)
			S_LD_N: lm_raddr = bn_q;
			S_LD_O: lm_raddr = bo_q;
			S_FL_RD: begin
				if (swp_q < CW'(ENERGY_BINS)) begin
					lm_raddr = swp_q[BW-1:0];
				end
			end
			S_CLR: begin
				lm_waddr = swp_q[BW-1:0];
				ld_we    = clr_all_q;
				cn_we    = 1'b1;
			end
			S_VISIT: begin
				lm_waddr = bv;
				ld_we    = 1'b1;
				cn_we    = 1'b1;
				ld_wd    = (ln_b > LOGD_MAX - inc) ? LOGD_MAX : ln_b + inc;
				cn_wd    = (cn_b == CNT_MAX) ? cn_b : cn_b + CNT_W'(1);
			end
			default: lm_raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			ld_mem[lm_waddr] <= ld_wd;
		end
		if (cn_we) begin
			cn_mem[lm_waddr] <= cn_wd;
		end
		ld_rd_q <= ld_mem[lm_raddr];
		cn_rd_q <= cn_mem[lm_raddr];
	end

	// Shared multiplier with its product register.
	always_comb begin
		unique case (state_q)
			S_EX_MUL: begin
				mul_a = term_q;
				mul_b = x_q;
			end
			S_PW_MUL: begin
				mul_a = r_q;
				mul_b = e1_q;
			end
			S_FL_MUL: begin
				mul_a = EXP_W'(fmn_q);
				mul_b = EXP_W'(fcnt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
	end

	// One restoring divider step per cycle.
	assign div_sh     = {div_rem_q, div_num_q[EXP_W-1]};
	assign div_ge     = div_sh >= {1'b0, div_den_q};
	assign div_rem_nx = div_ge ? DIV_VW'(div_sh - {1'b0, div_den_q}) : div_sh[DIV_VW-1:0];

	assign sum_clip = sum_q[EXP_W+1] ? '0 : sum_q[EXP_W-1:0];

	// Flatness: 5 * min * count >= 4 * sum over the nonzero bins.
	assign flat_lhs = (SUMW+3)'(prod_q[SUMW-1:0]) + ((SUMW+3)'(prod_q[SUMW-1:0]) << 2);
	assign flat_rhs = (SUMW+3)'(fsum_q) << 2;
	assign flat_ok  = (fcnt_q != '0) && (flat_lhs >= flat_rhs);

	// Sequencer with all control and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			side_q       <= SW'(SIDE_RST);
			levels_q     <= LW'(LEVELS_DEF);
			ci_q         <= CHK_W'(CHECK_DEF);
			final_q      <= STAGE_W'(FINAL_DEF);
			energy_q     <= EW'(E_RST);
			halving_q    <= '0;
			mc_q         <= '0;
			res_q        <= '0;
			init_q       <= 1'b1;
			clr_all_q    <= 1'b1;
			swp_q        <= '0;
			exp_e1_q     <= 1'b0;
			div_res_q    <= 1'b0;
			done_q       <= 1'b0;
			for (int i = 0; i < NSITE; i++) begin
				sp_vld_q[i] <= 1'b0;
			end
			act_q        <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			sp_q         <= '0;
			u_q          <= '0;
			rd_cnt_q     <= '0;
			old_q        <= '0;
			eqn_q        <= '0;
			eqo_q        <= '0;
			enew_q       <= '0;
			bn_q         <= '0;
			bo_q         <= '0;
			ln_n_q       <= '0;
			ln_o_q       <= '0;
			cn_n_q       <= '0;
			cn_o_q       <= '0;
			take_q       <= 1'b0;
			acc_q        <= 1'b0;
			flat_q       <= 1'b0;
			stat_q       <= 1'b0;
			x_q          <= '0;
			term_q       <= '0;
			sum_q        <= '0;
			k_q          <= '0;
			n_q          <= '0;
			r_q          <= '0;
			e1_q         <= '0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			div_rem_q    <= '0;
			div_cnt_q    <= '0;
			fsum_q       <= '0;
			fcnt_q       <= '0;
			fmn_q        <= '0;
			out_acc_q    <= 1'b0;
			out_energy_q <= '0;
			out_stage_q  <= '0;
			out_flat_q   <= 1'b0;
			out_fin_q    <= 1'b0;
			out_stat_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// Configuration writes.
			if (cfg_take) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SIDE: begin
						side_q   <= side_nx;
						energy_q <= EW'(0) - EW'(sq2);
						for (int i = 0; i < NSITE; i++) begin
							sp_vld_q[i] <= 1'b0;
						end
					end
					REG_LEVELS: begin
						if (cfg_data[3:0] < 4'd2) begin
							levels_q <= LW'(2);
						end else if (32'(cfg_data[3:0]) > 32'(MAX_LEVELS)) begin
							levels_q <= LW'(MAX_LEVELS);
						end else begin
							levels_q <= LW'(cfg_data[3:0]);
						end
					end
					REG_CHECK: begin
						ci_q <= cfg_data;
						// The move counter is zero during start-up, so the
						// residue stays zero then.
						if (!init_q) begin
							div_num_q <= EXP_W'(mc_q);
							div_den_q <= (cfg_data == '0) ? DIV_VW'(1) : cfg_data;
							div_rem_q <= '0;
							div_cnt_q <= '0;
							div_res_q <= 1'b1;
							state_q   <= S_DIV;
						end
					end
					REG_FINAL: begin
						if (cfg_data[4:0] == 5'd0) begin
							final_q <= STAGE_W'(1);
						end else if (cfg_data[4:0] > 5'(STAGE_MAX)) begin
							final_q <= STAGE_W'(STAGE_MAX);
						end else begin
							final_q <= cfg_data[4:0];
						end
					end
					default: final_q <= final_q;
				endcase
			end

			if (sp_we) begin
				sp_vld_q[site] <= 1'b1;
			end

			unique case (state_q)
				// Memory clearing sweep, after reset or after a flat pass.
				S_CLR: begin
					if (swp_q == CW'(ENERGY_BINS - 1)) begin
						swp_q <= '0;
						if (clr_all_q) begin
							clr_all_q <= 1'b0;
							exp_e1_q  <= 1'b1;
							x_q       <= ONE_Q24X;
							term_q    <= ONE_Q32;
							sum_q     <= (EXP_W+2)'(ONE_Q32);
							k_q       <= 4'd1;
							state_q   <= S_EX_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						swp_q <= swp_q + CW'(1);
					end
				end

				S_IDLE: begin
					if (start) begin
						act_q    <= action;
						row_q    <= row;
						col_q    <= col;
						sp_q     <= sp_in;
						u_q      <= uniform;
						acc_q    <= 1'b0;
						flat_q   <= 1'b0;
						stat_q   <= oor;
						rd_cnt_q <= '0;
						eqn_q    <= '0;
						eqo_q    <= '0;
						if (oor || (action && fin_now)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end

				// Center spin, then neighbor matches against new and old spin.
				S_RD: begin
					if (rd_cnt_q == 3'd1) begin
						old_q <= spv;
					end
					if (rd_cnt_q >= 3'd2) begin
						eqn_q <= eqn_q + 3'(spv == sp_q);
						eqo_q <= eqo_q + 3'(spv == old_q);
					end
					if (rd_cnt_q == 3'd5) begin
						state_q <= S_EVAL;
					end else begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end
				end

				S_EVAL: begin
					enew_q <= enew_c;
					bo_q   <= bin_of(energy_q);
					bn_q   <= bin_of(enew_c);
					if (!act_q) begin
						energy_q <= enew_c;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_LD_N;
					end
				end

				S_LD_N: state_q <= S_LD_O;

				S_LD_O: begin
					ln_n_q  <= ld_rd_q;
					cn_n_q  <= cn_rd_q;
					state_q <= S_CMP;
				end

				S_CMP: begin
					ln_o_q  <= ld_rd_q;
					cn_o_q  <= cn_rd_q;
					state_q <= S_GATE;
				end

				// Downhill or level accepts, a rise of 16.0 or more rejects.
				S_GATE: begin
					if (ln_n_q <= ln_o_q) begin
						take_q  <= 1'b1;
						state_q <= S_VISIT;
					end else if (dlog >= D_LIMIT) begin
						take_q  <= 1'b0;
						state_q <= S_VISIT;
					end else begin
						exp_e1_q <= 1'b0;
						x_q      <= EXP_W'(dlog[FRAC_W-1:0]);
						n_q      <= dlog[FRAC_W+3:FRAC_W];
						term_q   <= ONE_Q32;
						sum_q    <= (EXP_W+2)'(ONE_Q32);
						k_q      <= 4'd1;
						state_q  <= S_EX_MUL;
					end
				end

				S_EX_MUL: state_q <= S_EX_DIV0;

				S_EX_DIV0: begin
					div_num_q <= prod_q[FRAC_W +: EXP_W];
					div_den_q <= DIV_VW'(k_q);
					div_rem_q <= '0;
					div_cnt_q <= '0;
					div_res_q <= 1'b0;
					state_q   <= S_DIV;
				end

				S_DIV: begin
					div_num_q <= {div_num_q[EXP_W-2:0], div_ge};
					div_rem_q <= div_rem_nx;
					if (div_cnt_q == 6'(EXP_W - 1)) begin
						if (div_res_q) begin
							res_q   <= div_rem_nx;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EX_ACC;
						end
					end else begin
						div_cnt_q <= div_cnt_q + 6'd1;
					end
				end

				// Alternating series: odd terms subtract.
				S_EX_ACC: begin
					term_q <= div_num_q;
					if (k_q[0]) begin
						sum_q <= sum_q - (EXP_W+2)'(div_num_q);
					end else begin
						sum_q <= sum_q + (EXP_W+2)'(div_num_q);
					end
					if (k_q == 4'(EXP_TERMS)) begin
						state_q <= S_EX_END;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_EX_MUL;
					end
				end

				S_EX_END: begin
					if (exp_e1_q) begin
						e1_q     <= sum_clip;
						exp_e1_q <= 1'b0;
						init_q   <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						r_q <= sum_clip;
						if (n_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_PW_MUL;
						end
					end
				end

				S_PW_MUL: state_q <= S_PW_SH;

				// One factor of exp(-1) per whole unit of the rise.
				S_PW_SH: begin
					r_q <= prod_q[32 +: EXP_W];
					n_q <= n_q - 4'd1;
					if (n_q == 4'd1) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_PW_MUL;
					end
				end

				S_DECIDE: begin
					take_q  <= {1'b0, u_q} < r_q[32:16];
					state_q <= S_VISIT;
				end

				// Bump density and count, advance the move counter.
				S_VISIT: begin
					acc_q <= take_q;
					if (take_q) begin
						energy_q <= enew_q;
					end
					mc_q <= mc_q + MC_W'(1);
					if (mc_q == '1) begin
						res_q <= '0;
					end else if (res_q + CHK_W'(1) == ci_eff) begin
						res_q <= '0;
					end else begin
						res_q <= res_q + CHK_W'(1);
					end
					if (res_q == '0) begin
						swp_q   <= '0;
						fsum_q  <= '0;
						fcnt_q  <= '0;
						fmn_q   <= '0;
						state_q <= S_FL_RD;
					end else begin
						state_q <= S_DONE;
					end
				end

				// Walk the histogram: min, sum and count of nonzero bins.
				S_FL_RD: begin
					if (swp_q != '0) begin
						if (cn_rd_q != '0) begin
							if ((fcnt_q == '0) || (cn_rd_q < fmn_q)) begin
								fmn_q <= cn_rd_q;
							end
							fsum_q <= fsum_q + SUMW'(cn_rd_q);
							fcnt_q <= fcnt_q + CW'(1);
						end
					end
					if (swp_q == CW'(ENERGY_BINS)) begin
						state_q <= S_FL_MUL;
					end else begin
						swp_q <= swp_q + CW'(1);
					end
				end

				S_FL_MUL: state_q <= S_FL_CMP;

				S_FL_CMP: begin
					if (flat_ok) begin
						flat_q <= 1'b1;
						if (halving_q < STAGE_W'(STAGE_MAX)) begin
							halving_q <= halving_q + STAGE_W'(1);
						end
						swp_q   <= '0;
						state_q <= S_CLR;
					end else begin
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					done_q       <= 1'b1;
					out_acc_q    <= acc_q;
					out_energy_q <= energy_q;
					out_stage_q  <= halving_q;
					out_flat_q   <= flat_q;
					out_fin_q    <= fin_now;
					out_stat_q   <= stat_q;
					state_q      <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign accepted = out_acc_q;
	assign energy   = out_energy_q;
	assign stage    = out_stage_q;
	assign flat_now = out_flat_q;
	assign finished = out_fin_q;
	assign status   = out_stat_q;

`ifndef SYNTHESIS
	// A result appears only once the sequencer is back to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request always makes the sequencer go busy.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted without going busy");

	// Results never come in consecutive cycles.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("back to back results");

	// An ignored coordinate never accepts a move nor halves ln f.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (!accepted && !flat_now))
		else $error("ignored request changed the sampler");

	// The exp(-1) factor is known before any load or move reads the lattice.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> !init_q)
		else $error("move served before start-up finished");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wang-Landau Potts step testbench
// Drives load and move requests through the start/busy port, reconfigures the
// sampler between phases and checks every result against an in-house model of
// the lattice, log density, histogram and flatness logic.
// ----------------------------------------------------------------------------
module tb;
	import wlps_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int SIDE_MAX     = 16;
	localparam int LEVELS_MAX   = 8;
	localparam int NBINS        = 513;
	localparam longint unsigned LOGD_TOP = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		bit        action;
		bit [3:0]  row;
		bit [3:0]  col;
		bit [3:0]  spin;
		bit [15:0] uniform;
	} potts_req_t;

	typedef struct {
		bit              accepted;
		bit signed [9:0] energy;
		bit [4:0]        stage;
		bit              flat_now;
		bit              finished;
		bit              status;
	} potts_res_t;

	// Sampler model with its own queue of expected results.
	class potts_scoreboard;
		bit [3:0]        lattice[SIDE_MAX*SIDE_MAX];
		longint unsigned logd[NBINS];
		int unsigned     visits[NBINS];
		int              energy_now;
		int unsigned     halvings;
		bit [15:0]       moves;
		int unsigned     side, levels, chk, final_k;
		potts_res_t      expected_q[$];
		int              errors;

		function void clear_lattice();
			foreach (lattice[i]) lattice[i] = 4'd1;
			energy_now = -2 * int'(side * side);
		endfunction

		function void reset_state();
			side = SIDE_DEF;
			levels = LEVELS_DEF;
			chk = CHECK_DEF;
			final_k = FINAL_DEF;
			clear_lattice();
			foreach (logd[i]) logd[i] = 0;
			foreach (visits[i]) visits[i] = 0;
			halvings = 0;
			moves = 0;
			errors = 0;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void write_reg(cfg_reg_t idx, bit [15:0] v);
			case (idx)
				REG_SIDE: begin
					side = clip(v[4:0], 2, SIDE_MAX);
					clear_lattice();
				end
				REG_LEVELS: levels = clip(v[3:0], 2, LEVELS_MAX);
				REG_CHECK:  chk = v;
				REG_FINAL:  final_k = clip(v[4:0], 1, 24);
			endcase
		endfunction

		function int same_neighbors(int unsigned r, int unsigned c, bit [3:0] v);
			int unsigned up, dn, lf, rt;
			int n;
			up = (r + side - 1) % side;
			dn = (r + 1) % side;
			lf = (c + side - 1) % side;
			rt = (c + 1) % side;
			n = 0;
			n += (lattice[up*SIDE_MAX + c] == v);
			n += (lattice[dn*SIDE_MAX + c] == v);
			n += (lattice[r*SIDE_MAX + lf] == v);
			n += (lattice[r*SIDE_MAX + rt] == v);
			return n;
		endfunction

		// exp(-x) in Q32 for a Q24 argument, twelve-term series.
		function longint unsigned exp_neg(longint unsigned x);
			longint sum;
			longint unsigned term;
			sum = 64'sd1 <<< 32;
			term = 64'd1 << 32;
			for (int k = 1; k <= 12; k++) begin
				term = ((term * x) >> 24) / k;
				if (k % 2) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			return longint'(sum);
		endfunction

		function longint unsigned accept_limit(longint unsigned d);
			longint unsigned r, e1, n;
			if (d >= (64'd16 << 24)) return 0;
			n = d >> 24;
			r = exp_neg(d & 64'hFF_FFFF);
			e1 = exp_neg(64'd1 << 24);
			for (longint unsigned i = 0; i < n; i++) r = (r * e1) >> 32;
			return r >> 16;
		endfunction

		function int unsigned bin_of(int e);
			int unsigned b;
			b = (e < 0) ? -e : 0;
			return (b > NBINS - 1) ? NBINS - 1 : b;
		endfunction

		function void visit_bin(int unsigned b);
			longint unsigned inc;
			inc = 64'd1 << (24 - ((halvings > 24) ? 24 : halvings));
			logd[b] = (logd[b] > LOGD_TOP - inc) ? LOGD_TOP : logd[b] + inc;
			if (visits[b] != 32'hFFFF_FFFF) visits[b]++;
		endfunction

		// Flat when every visited bin holds at least 0.8 of the mean.
		function bit histogram_flat();
			longint unsigned sum, cnt, mn;
			sum = 0;
			cnt = 0;
			mn = 0;
			foreach (visits[i]) begin
				if (visits[i] != 0) begin
					if (cnt == 0 || visits[i] < mn) mn = visits[i];
					sum += visits[i];
					cnt++;
				end
			end
			return (cnt != 0) && (5 * mn * cnt >= 4 * sum);
		endfunction

		function void note_request(potts_req_t q);
			potts_res_t x;
			bit [3:0] sp, old;
			int unsigned idx, bo, bn;
			int e_new;
			bit take;
			x = '{default: 0};
			sp = 4'(clip(q.spin, 1, levels));
			if (q.row >= side || q.col >= side) begin
				x.status = 1;
			end else begin
				idx = q.row * SIDE_MAX + q.col;
				old = lattice[idx];
				e_new = energy_now - same_neighbors(q.row, q.col, sp)
					+ same_neighbors(q.row, q.col, old);
				if (!q.action) begin
					lattice[idx] = sp;
					energy_now = e_new;
				end else if (halvings < final_k) begin
					bo = bin_of(energy_now);
					bn = bin_of(e_new);
					take = (logd[bn] <= logd[bo]) ||
						(q.uniform < accept_limit(logd[bn] - logd[bo]));
					if (take) begin
						lattice[idx] = sp;
						energy_now = e_new;
						visit_bin(bn);
						x.accepted = 1;
					end else begin
						visit_bin(bo);
					end
					if (moves % ((chk != 0) ? chk : 1) == 0 && histogram_flat()) begin
						if (halvings < 24) halvings++;
						foreach (visits[i]) visits[i] = 0;
						x.flat_now = 1;
					end
					moves++;
				end
			end
			x.energy = 10'(energy_now);
			x.stage = 5'(halvings);
			x.finished = (halvings >= final_k);
			expected_q = {expected_q, x};
		endfunction

		function void check_result(potts_res_t a);
			potts_res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (a.accepted !== e.accepted) begin
				$display("%0t: accepted exp %0d got %0d", $time, e.accepted, a.accepted);
				errors++;
			end
			if (a.energy !== e.energy) begin
				$display("%0t: energy exp %0d got %0d", $time, e.energy, a.energy);
				errors++;
			end
			if (a.stage !== e.stage) begin
				$display("%0t: stage exp %0d got %0d", $time, e.stage, a.stage);
				errors++;
			end
			if (a.flat_now !== e.flat_now) begin
				$display("%0t: flat_now exp %0d got %0d", $time, e.flat_now, a.flat_now);
				errors++;
			end
			if (a.finished !== e.finished) begin
				$display("%0t: finished exp %0d got %0d", $time, e.finished, a.finished);
				errors++;
			end
			if (a.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, a.status);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, action;
	logic [3:0] row, col;
	logic [SPIN_W-1:0] spin;
	logic [UNI_W-1:0] uniform;
	logic done, accepted, flat_now, finished, status;
	logic signed [9:0] energy;
	logic [STAGE_W-1:0] stage;
	logic cfg_valid, cfg_ready;
	cfg_reg_t cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	potts_scoreboard sb;
	int unsigned cycles;

	wang_landau_potts_step uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .row(row), .col(col), .spin(spin), .uniform(uniform),
		.done(done), .accepted(accepted), .energy(energy), .stage(stage),
		.flat_now(flat_now), .finished(finished), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Result monitor and run-time guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("wang_landau_potts_step regression: fail");
			$finish;
		end
		if (arst_n && done)
			sb.check_result('{accepted, energy, stage, flat_now, finished, status});
	end

	// Issue one request; returns at a falling edge with start still high.
	task automatic send_request(bit act, bit [3:0] r, bit [3:0] c, bit [3:0] s,
			bit [15:0] u);
		potts_req_t q;
		q = '{act, r, c, s, u};
		start = 1;
		action = act;
		row = r;
		col = c;
		spin = s;
		uniform = u;
		do @(posedge clk); while (busy);
		sb.note_request(q);
		@(negedge clk);
	endtask

	task automatic pause_requests(int n);
		start = 0;
		repeat (n) @(negedge clk);
	endtask

	// Register write once all results are back.
	task automatic write_reg(cfg_reg_t idx, bit [15:0] v);
		start = 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Random traffic: mostly in-range moves, some loads and stray coordinates.
	task automatic random_phase(int n, bit gappy);
		int unsigned sel, burst;
		bit [3:0] r, c;
		burst = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			r = 4'($urandom_range(0, sb.side - 1));
			c = 4'($urandom_range(0, sb.side - 1));
			if (sel < 8) begin
				r = 4'($urandom_range(0, 15));
				c = 4'($urandom_range(0, 15));
			end
			send_request(sel >= 8 && sel < 28 ? 1'b0 : 1'b1, r, c,
				$urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, sb.levels)),
				16'($urandom_range(0, 65535)));
			if (gappy && --burst == 0) begin
				pause_requests($urandom_range(1, 6));
				burst = $urandom_range(1, 8);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles = 0;
		arst_n = 0;
		start = 0;
		action = 0;
		row = 0;
		col = 0;
		spin = 0;
		uniform = 0;
		cfg_valid = 0;
		cfg_index = REG_SIDE;
		cfg_data = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// Out-of-range register values clamp; check interval of zero acts as one.
		write_reg(REG_SIDE, 16'd0);
		write_reg(REG_LEVELS, 16'd15);
		write_reg(REG_CHECK, 16'd0);
		write_reg(REG_FINAL, 16'd31);

		// Spin clamping, stray coordinates and uniform extremes on the smallest lattice.
		send_request(0, 0, 0, 4'd0, 16'd0);
		send_request(0, 1, 1, 4'd15, 16'hFFFF);
		send_request(0, 15, 0, 4'd3, 16'd0);
		send_request(1, 0, 15, 4'd2, 16'd0);
		send_request(1, 0, 1, 4'd8, 16'd0);
		send_request(1, 1, 0, 4'd5, 16'hFFFF);
		send_request(1, 1, 1, 4'd1, 16'hFFFF);
		send_request(1, 0, 0, 4'd7, 16'd0);
		send_request(0, 1, 0, 4'd8, 16'hFFFF);

		// Finish at the lowest final stage; moves are then ignored, loads are not.
		write_reg(REG_SIDE, 16'd4);
		write_reg(REG_LEVELS, 16'd0);
		write_reg(REG_CHECK, 16'd1);
		write_reg(REG_FINAL, 16'd0);
		send_request(1, 3, 3, 4'd2, 16'd0);
		send_request(1, 2, 3, 4'd2, 16'hFFFF);
		send_request(0, 3, 2, 4'd2, 16'd0);
		send_request(0, 3, 3, 4'd9, 16'd0);
		send_request(1, 4, 0, 4'd2, 16'd0);

		// Spins above a lowered level count stay in place.
		write_reg(REG_SIDE, 16'd31);
		write_reg(REG_LEVELS, 16'd8);
		write_reg(REG_FINAL, 16'd24);
		write_reg(REG_CHECK, 16'hFFFF);
		send_request(0, 15, 15, 4'd8, 16'd0);
		send_request(0, 15, 14, 4'd8, 16'd0);
		write_reg(REG_LEVELS, 16'd2);
		send_request(1, 15, 15, 4'd1, 16'd100);
		send_request(1, 0, 0, 4'd2, 16'd100);

		random_phase(60, 1);
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_SIDE, 16'($urandom_range(2, 16)));
			write_reg(REG_LEVELS, 16'($urandom_range(2, 8)));
			write_reg(REG_CHECK, (p == 4) ? 16'd1 : 16'($urandom_range(20, 150)));
			write_reg(REG_FINAL, (p == 4) ? 16'($urandom_range(1, 24)) : 16'd24);
			random_phase(70, p % 2);
		end

		start = 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("wang_landau_potts_step regression: pass");
		else
			$display("wang_landau_potts_step regression: fail");
		$finish;
	end

endmodule

### sim.f
src/wlps_pkg.sv
src/wang_landau_potts_step.sv
tb/tb.sv
